@@ sv/tlg_pkg.sv @@
// shared types and constants for the toroidal life generation block
`timescale 1ns / 1ps

package tlg_pkg;

  // default grid size
  localparam int unsigned GridRowsDefault = 24;
  localparam int unsigned GridColsDefault = 80;

  // fixed field widths of the command beat
  localparam int unsigned CmdW     = 2;
  localparam int unsigned RowPortW = 5;
  localparam int unsigned ColPortW = 7;
  // width that holds any port index and any grid size up to 256
  localparam int unsigned IdxExtW  = 9;

  // neighbour count and life rule thresholds
  localparam int unsigned NbrW       = 4;
  localparam logic [NbrW-1:0] LifeBirth = NbrW'(3);
  localparam logic [NbrW-1:0] LifeKeep  = NbrW'(2);

  // command queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // classified command as it sits in the queue
  typedef struct packed {
    cmd_e                cmd;
    logic                in_range;
    logic                alive;
    logic [RowPortW-1:0] row;
    logic [ColPortW-1:0] col;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_sts_t;

  typedef struct packed {
    logic stepping;
    logic res_load;
  } eng_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_CELL_WR = 3'd1,
    ST_CELL_RD = 3'd2,
    ST_STEP    = 3'd3,
    ST_RESP    = 3'd4
  } eng_state_e;

endpackage

@@ sv/toroidal_life_generation_top.sv @@
// top level of the toroidal life generation block (rule b3/s23)
`timescale 1ns / 1ps

// usage
//   input channel: one beat per command (clear, write cell, step, read cell)
//   on command_i, row_i, col_i, alive_in_i, taken when in_valid_i is high and
//   in_stall_o is low; a two-entry queue lets beats queue up while the grid
//   engine is busy
//   output channel: exactly one beat per command, in command order, on
//   cell_alive_o, taken when out_valid_o is high and out_stall_i is low;
//   cell_alive_o is the cell value for an in-range read and 0 otherwise
//   out-of-range writes are dropped, out-of-range reads return 0
// sequence, from queue head to result in the output register
//   clear and out-of-range write and read: straight to the response state;
//   in-range write and read: one registered row read, then the cell access
//   step: the engine reads one row per cycle from the live bank and writes
//   one new row per cycle into the other bank, then swaps banks; the single
//   read port sets this rate
// reset: asynchronous, active low; all rows marked dead at once through
//   per-row valid bits, so no clearing pass is needed
// stall: a result waits in the output register; the engine holds its next
//   result until that beat is taken; the queue takes commands until full
module toroidal_life_generation_top #(
  parameter int unsigned GRID_ROWS = tlg_pkg::GridRowsDefault,
  parameter int unsigned GRID_COLS = tlg_pkg::GridColsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tlg_pkg::CmdW-1:0]     command_i,
  input  logic [tlg_pkg::RowPortW-1:0] row_i,
  input  logic [tlg_pkg::ColPortW-1:0] col_i,
  input  logic                         alive_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         cell_alive_o
);

  tlg_pkg::fifo_sts_t q_sts;
  tlg_pkg::eng_sts_t  eng_sts;
  tlg_pkg::op_t       push_op;
  tlg_pkg::op_t       head_op;
  logic               q_push;
  logic               q_pop;

  // classify and range-check the incoming command
  tlg_front #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .alive_in_i (alive_in_i),
    .q_sts_i    (q_sts),
    .push_o     (q_push),
    .op_o       (push_op)
  );

  // decouples command intake from grid work
  tlg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .op_i   (push_op),
    .pop_i  (q_pop),
    .op_o   (head_op),
    .sts_o  (q_sts)
  );

  // grid storage, cell access and generation step
  tlg_engine #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_sts_i      (q_sts),
    .op_i         (head_op),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cell_alive_o (cell_alive_o),
    .sts_o        (eng_sts)
  );

  // engine only takes a command that is really queued
  a_pop_needs_entry : assert property (
    @(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_sts.empty
  ) else $error("engine popped an empty queue");

  // an accepted beat is visible to the engine on the next cycle
  a_push_lands : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !q_sts.empty
  ) else $error("accepted command missing from queue");

  // every command passes through the idle and the response state, so results never load back to back
  a_result_spacing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) eng_sts.res_load |=> !eng_sts.res_load
  ) else $error("results loaded on back-to-back cycles");

  // no result leaves while a step is still sweeping the grid
  a_no_result_mid_step : assert property (
    @(posedge clk_i) disable iff (!rst_ni) eng_sts.stepping |-> !eng_sts.res_load
  ) else $error("result loaded during a generation step");

endmodule

@@ sv/tlg_front.sv @@
// command front end: accepts beats and classifies them for the queue
`timescale 1ns / 1ps

module tlg_front #(
  parameter int unsigned GRID_ROWS = tlg_pkg::GridRowsDefault,
  parameter int unsigned GRID_COLS = tlg_pkg::GridColsDefault
) (
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tlg_pkg::CmdW-1:0]     command_i,
  input  logic [tlg_pkg::RowPortW-1:0] row_i,
  input  logic [tlg_pkg::ColPortW-1:0] col_i,
  input  logic                         alive_in_i,
  input  tlg_pkg::fifo_sts_t           q_sts_i,
  output logic                         push_o,
  output tlg_pkg::op_t                 op_o
);

  logic [tlg_pkg::IdxExtW-1:0] row_ext;
  logic [tlg_pkg::IdxExtW-1:0] col_ext;
  tlg_pkg::cmd_e               cmd;

  assign row_ext = tlg_pkg::IdxExtW'(row_i);
  assign col_ext = tlg_pkg::IdxExtW'(col_i);
  assign cmd     = tlg_pkg::cmd_e'(command_i);

  assign in_stall_o = q_sts_i.full;
  assign push_o     = in_valid_i && !q_sts_i.full;

  assign op_o.cmd      = cmd;
  assign op_o.in_range = (row_ext < tlg_pkg::IdxExtW'(GRID_ROWS)) &&
                         (col_ext < tlg_pkg::IdxExtW'(GRID_COLS));
  // only a write carries a cell value
  assign op_o.alive    = (cmd == tlg_pkg::CMD_WRITE) && alive_in_i;
  assign op_o.row      = row_i;
  assign op_o.col      = col_i;

endmodule

@@ sv/tlg_queue.sv @@
// short command queue between front end and grid engine
`timescale 1ns / 1ps

module tlg_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tlg_pkg::op_t       op_i,
  input  logic               pop_i,
  output tlg_pkg::op_t       op_o,
  output tlg_pkg::fifo_sts_t sts_o
);

  tlg_pkg::op_t                  entry_q [tlg_pkg::QueueDepth];
  logic [tlg_pkg::QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [tlg_pkg::QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [tlg_pkg::QueueCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + tlg_pkg::QueuePtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + tlg_pkg::QueuePtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + tlg_pkg::QueueCntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - tlg_pkg::QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= op_i;
    end
  end

  assign op_o        = entry_q[rd_ptr_q];
  assign sts_o.full  = (cnt_q == tlg_pkg::QueueCntW'(tlg_pkg::QueueDepth));
  assign sts_o.empty = (cnt_q == '0);

endmodule

@@ sv/tlg_engine.sv @@
// grid engine: two row-wide grid banks, cell access and generation step
`timescale 1ns / 1ps

module tlg_engine #(
  parameter int unsigned GRID_ROWS = tlg_pkg::GridRowsDefault,
  parameter int unsigned GRID_COLS = tlg_pkg::GridColsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tlg_pkg::fifo_sts_t q_sts_i,
  input  tlg_pkg::op_t       op_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               cell_alive_o,
  output tlg_pkg::eng_sts_t  sts_o
);

  localparam int unsigned RowW = $clog2(GRID_ROWS);
  localparam int unsigned ColW = $clog2(GRID_COLS);
  localparam int unsigned KW   = $clog2(GRID_ROWS + 3);

  tlg_pkg::eng_state_e state_q, state_d;

  // grid banks, one row per word
  logic [GRID_COLS-1:0] mem0 [GRID_ROWS];
  logic [GRID_COLS-1:0] mem1 [GRID_ROWS];
  logic [GRID_COLS-1:0] rd0_q, rd1_q;
  logic                 rd_vld_q;
  logic [1:0][GRID_ROWS-1:0] vld_q;
  logic                 cur_q;

  tlg_pkg::op_t         op_q;
  logic [KW-1:0]        k_q, k_d;
  logic [KW-1:0]        kd_q;
  logic                 dv_q;
  logic [GRID_COLS-1:0] w_top_q, w_mid_q;
  logic                 res_q, res_d;
  logic                 out_valid_q;
  logic                 cell_alive_q;

  logic [RowW-1:0]      raddr;
  logic [RowW-1:0]      head_row, op_row, step_addr, step_waddr;
  logic [ColW-1:0]      op_col;
  logic [tlg_pkg::IdxExtW-1:0] head_row_ext, op_row_ext, op_col_ext;
  logic [KW-1:0]        km1, km2;
  logic [GRID_COLS-1:0] rd_row, new_row, wr_data;
  logic                 wr_en, wr_bank;
  logic [RowW-1:0]      wr_addr;
  logic                 issue, clr, flip, out_load, op_load, win_shift;

  assign head_row_ext = tlg_pkg::IdxExtW'(op_i.row);
  assign head_row     = head_row_ext[RowW-1:0];
  assign op_row_ext   = tlg_pkg::IdxExtW'(op_q.row);
  assign op_row       = op_row_ext[RowW-1:0];
  assign op_col_ext   = tlg_pkg::IdxExtW'(op_q.col);
  assign op_col       = op_col_ext[ColW-1:0];

  // step reads rows last, 0, 1, .. last, 0 of the live bank
  assign km1 = k_q - KW'(1);
  assign km2 = kd_q - KW'(2);
  always_comb begin
    if (k_q == '0) begin
      step_addr = RowW'(GRID_ROWS - 1);
    end else if (k_q == KW'(GRID_ROWS + 1)) begin
      step_addr = '0;
    end else begin
      step_addr = km1[RowW-1:0];
    end
  end
  assign step_waddr = km2[RowW-1:0];

  // rows never written since clear read as dead
  assign rd_row = rd_vld_q ? (cur_q ? rd1_q : rd0_q) : '0;

  // one full row of the next generation per cycle
  for (genvar c = 0; c < GRID_COLS; c++) begin : g_cell
    localparam int Lf = (c == 0) ? GRID_COLS - 1 : c - 1;
    localparam int Rt = (c == GRID_COLS - 1) ? 0 : c + 1;
    logic [tlg_pkg::NbrW-1:0] cnt;
    assign cnt = tlg_pkg::NbrW'(w_top_q[Lf]) + tlg_pkg::NbrW'(w_top_q[c]) +
                 tlg_pkg::NbrW'(w_top_q[Rt]) + tlg_pkg::NbrW'(w_mid_q[Lf]) +
                 tlg_pkg::NbrW'(w_mid_q[Rt]) + tlg_pkg::NbrW'(rd_row[Lf]) +
                 tlg_pkg::NbrW'(rd_row[c])   + tlg_pkg::NbrW'(rd_row[Rt]);
    assign new_row[c] = (cnt == tlg_pkg::LifeBirth) ||
                        (w_mid_q[c] && (cnt == tlg_pkg::LifeKeep));
  end

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    op_load   = 1'b0;
    raddr     = '0;
    wr_en     = 1'b0;
    wr_bank   = cur_q;
    wr_addr   = op_row;
    wr_data   = rd_row;
    k_d       = k_q;
    issue     = 1'b0;
    clr       = 1'b0;
    flip      = 1'b0;
    res_d     = res_q;
    out_load  = 1'b0;
    win_shift = 1'b0;
    case (state_q)
      tlg_pkg::ST_IDLE: begin
        if (!q_sts_i.empty) begin
          pop_o   = 1'b1;
          op_load = 1'b1;
          res_d   = 1'b0;
          if (op_i.in_range) begin
            raddr = head_row;
          end
          case (op_i.cmd)
            tlg_pkg::CMD_CLEAR: begin
              clr     = 1'b1;
              state_d = tlg_pkg::ST_RESP;
            end
            tlg_pkg::CMD_WRITE: begin
              state_d = op_i.in_range ? tlg_pkg::ST_CELL_WR : tlg_pkg::ST_RESP;
            end
            tlg_pkg::CMD_READ: begin
              state_d = op_i.in_range ? tlg_pkg::ST_CELL_RD : tlg_pkg::ST_RESP;
            end
            tlg_pkg::CMD_STEP: begin
              k_d     = '0;
              state_d = tlg_pkg::ST_STEP;
            end
            default: begin
              state_d = tlg_pkg::ST_RESP;
            end
          endcase
        end
      end
      tlg_pkg::ST_CELL_WR: begin
        wr_en           = 1'b1;
        wr_data[op_col] = op_q.alive;
        state_d         = tlg_pkg::ST_RESP;
      end
      tlg_pkg::ST_CELL_RD: begin
        res_d   = rd_row[op_col];
        state_d = tlg_pkg::ST_RESP;
      end
      tlg_pkg::ST_STEP: begin
        raddr = step_addr;
        if (k_q <= KW'(GRID_ROWS + 1)) begin
          issue = 1'b1;
          k_d   = k_q + KW'(1);
        end
        if (dv_q) begin
          win_shift = 1'b1;
          if (kd_q >= KW'(2)) begin
            wr_en   = 1'b1;
            wr_bank = ~cur_q;
            wr_addr = step_waddr;
            wr_data = new_row;
          end
          if (kd_q == KW'(GRID_ROWS + 1)) begin
            flip    = 1'b1;
            state_d = tlg_pkg::ST_RESP;
          end
        end
      end
      tlg_pkg::ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = tlg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tlg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlg_pkg::ST_IDLE;
      cur_q       <= 1'b0;
      vld_q       <= '0;
      k_q         <= '0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      dv_q    <= issue;
      if (flip) begin
        cur_q <= ~cur_q;
      end
      if (clr) begin
        vld_q[cur_q] <= '0;
      end
      if (wr_en) begin
        vld_q[wr_bank][wr_addr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_load) begin
      op_q <= op_i;
    end
    if (issue) begin
      kd_q <= k_q;
    end
    if (win_shift) begin
      w_top_q <= w_mid_q;
      w_mid_q <= rd_row;
    end
    res_q <= res_d;
    if (out_load) begin
      cell_alive_q <= res_q;
    end
  end

  // grid banks with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en && !wr_bank) begin
      mem0[wr_addr] <= wr_data;
    end
    if (wr_en && wr_bank) begin
      mem1[wr_addr] <= wr_data;
    end
    rd0_q    <= mem0[raddr];
    rd1_q    <= mem1[raddr];
    rd_vld_q <= vld_q[cur_q][raddr];
  end

  assign out_valid_o    = out_valid_q;
  assign cell_alive_o   = cell_alive_q;
  assign sts_o.stepping = (state_q == tlg_pkg::ST_STEP);
  assign sts_o.res_load = out_load;

endmodule
